[hdl/mcdi_pkg.sv]
// ============================================================================
// mcdi_pkg
// Shared types, constants and helpers for the deinterlacer pixel merge.
// ============================================================================
package mcdi_pkg;

    // Pixel and row geometry
    localparam int PIX_W     = 8;
    localparam int SRC_TAPS  = 7;               // offsets -3..3
    localparam int MC_TAPS   = 5;               // offsets -2..2
    localparam int SRC_W     = SRC_TAPS * PIX_W;
    localparam int MC_W      = MC_TAPS * PIX_W;
    localparam int NUM_DIRS  = 5;               // directions -2..2

    // Arithmetic widths
    localparam int SCORE_W   = PIX_W + 2;       // sum of three abs diffs
    localparam int BEST_W    = SCORE_W + 1;     // signed, base score minus one
    localparam int DIFF_W    = PIX_W + 1;       // signed compensated minus source
    localparam int DIR_W     = 3;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Direction codes, used as index into the per-direction arrays
    localparam logic [DIR_W-1:0] DIR_M2 = 3'd0;
    localparam logic [DIR_W-1:0] DIR_M1 = 3'd1;
    localparam logic [DIR_W-1:0] DIR_0  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_P1 = 3'd3;
    localparam logic [DIR_W-1:0] DIR_P2 = 3'd4;

    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [SCORE_W-1:0] score_t;

    // Candidate set handed from the scoring stage to the merge stage
    typedef struct packed {
        logic [NUM_DIRS-1:0][SCORE_W-1:0] score;  // indexed by direction code
        logic [NUM_DIRS-1:0][DIFF_W-1:0]  da;     // above: mc minus src, offset-2
        logic [NUM_DIRS-1:0][DIFF_W-1:0]  db;     // below: mc minus src, offset-2
        pix_t                             center;
        logic                             in_window;
    } cand_t;

    // Absolute difference of two pixels
    function automatic pix_t abs_diff(input pix_t x, input pix_t y);
        return (x > y) ? pix_t'(x - y) : pix_t'(y - x);
    endfunction

    // Magnitude of a 9-bit signed difference
    function automatic pix_t mag9(input logic signed [DIFF_W-1:0] d);
        logic signed [DIFF_W-1:0] n;
        n = (d < 0) ? -d : d;
        return n[PIX_W-1:0];
    endfunction

endpackage

[hdl/mcdi_score.sv]
// ============================================================================
// mcdi_score
// Direction scores and correction differences, registered for the merge.
// ============================================================================
module mcdi_score (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [mcdi_pkg::SRC_W-1:0] src_above,
    input  logic [mcdi_pkg::SRC_W-1:0] src_below,
    input  logic [mcdi_pkg::MC_W-1:0]  mc_above,
    input  logic [mcdi_pkg::MC_W-1:0]  mc_below,
    input  mcdi_pkg::pix_t        center,
    input  logic                  in_window,
    output logic                  out_valid,
    output mcdi_pkg::cand_t       cand
);
    import mcdi_pkg::*;

    pix_t  a  [SRC_TAPS];
    pix_t  b  [SRC_TAPS];
    pix_t  pa [MC_TAPS];
    pix_t  pb [MC_TAPS];
    cand_t cand_next;
    cand_t cand_reg;
    logic  valid_reg;

    // Unpack rows into taps (index = offset + half width)
    always_comb
    begin
        for (int i = 0; i < SRC_TAPS; i++)
        begin
            a[i] = src_above[i*PIX_W +: PIX_W];
            b[i] = src_below[i*PIX_W +: PIX_W];
        end
        for (int i = 0; i < MC_TAPS; i++)
        begin
            pa[i] = mc_above[i*PIX_W +: PIX_W];
            pb[i] = mc_below[i*PIX_W +: PIX_W];
        end
    end

    // Direction n (offset n-2): pairs a[n+k] with b[4-n+k], k = 0..2
    always_comb
    begin
        cand_next.center    = center;
        cand_next.in_window = in_window;
        for (int n = 0; n < NUM_DIRS; n++)
        begin
            cand_next.score[n] = {2'b00, abs_diff(a[n],     b[4-n])}
                               + {2'b00, abs_diff(a[n + 1], b[5-n])}
                               + {2'b00, abs_diff(a[n + 2], b[6-n])};
            cand_next.da[n] = {1'b0, pa[n]} - {1'b0, a[n + 1]};
            cand_next.db[n] = {1'b0, pb[n]} - {1'b0, b[n + 1]};
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            cand_reg <= cand_next;
    end

    assign out_valid = valid_reg;
    assign cand      = cand_reg;

endmodule

[hdl/mcdi_merge.sv]
// ============================================================================
// mcdi_merge
// Direction pick, weighted merge of corrections, clamp and result register.
// ============================================================================
module mcdi_merge (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  mcdi_pkg::cand_t cand,
    output logic            out_valid,
    output mcdi_pkg::pix_t  pixel
);
    import mcdi_pkg::*;

    logic signed [BEST_W-1:0] best;
    logic [DIR_W-1:0]         sel;
    logic signed [DIFF_W-1:0] d0;
    logic signed [DIFF_W-1:0] d1;
    pix_t                     mag0;
    pix_t                     mag1;
    logic signed [DIFF_W-1:0] mdiff;
    pix_t                     m;
    logic signed [BEST_W-1:0] half_m;
    logic signed [BEST_W-1:0] s;
    logic signed [BEST_W-1:0] x;
    logic signed [BEST_W-1:0] x_adj;
    logic signed [BEST_W-1:0] q;
    logic signed [BEST_W:0]   t;
    pix_t                     clamped;
    pix_t                     pixel_next;
    pix_t                     pixel_reg;
    logic                     valid_reg;

    // Edge-directed search: left side first, then right side
    always_comb
    begin
        best = $signed({1'b0, cand.score[DIR_0]}) - BEST_W'(1);
        sel  = DIR_0;
        if ($signed({1'b0, cand.score[DIR_M1]}) < best)
        begin
            best = $signed({1'b0, cand.score[DIR_M1]});
            sel  = DIR_M1;
            if ($signed({1'b0, cand.score[DIR_M2]}) < best)
            begin
                best = $signed({1'b0, cand.score[DIR_M2]});
                sel  = DIR_M2;
            end
        end
        if ($signed({1'b0, cand.score[DIR_P1]}) < best)
        begin
            best = $signed({1'b0, cand.score[DIR_P1]});
            sel  = DIR_P1;
            if ($signed({1'b0, cand.score[DIR_P2]}) < best)
                sel = DIR_P2;
        end
    end

    // Magnitude-weighted average of the two corrections
    always_comb
    begin
        d0     = $signed(cand.da[sel]);
        d1     = $signed(cand.db[DIR_P2 - sel]);
        mag0   = mag9(d0);
        mag1   = mag9(d1);
        mdiff  = $signed({1'b0, mag0}) - $signed({1'b0, mag1});
        m      = mag9(mdiff);
        half_m = $signed({{(BEST_W-PIX_W+1){1'b0}}, m[PIX_W-1:1]});
        s      = BEST_W'(d0) + BEST_W'(d1);
        x      = (s > 0) ? (s - half_m) : (s + half_m);
        // halve with truncation toward zero
        x_adj  = x + $signed({{(BEST_W-1){1'b0}}, x[BEST_W-1]});
        q      = x_adj >>> 1;
        t      = $signed({{(BEST_W+1-PIX_W){1'b0}}, cand.center}) - (BEST_W+1)'(q);
    end

    // Clamp to pixel range, pass center through outside the image
    always_comb
    begin
        if (t < 0)
            clamped = '0;
        else if (t > $signed({{(BEST_W+1-PIX_W){1'b0}}, PIX_MAX}))
            clamped = PIX_MAX;
        else
            clamped = t[PIX_W-1:0];
        pixel_next = cand.in_window ? clamped : cand.center;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            pixel_reg <= pixel_next;
    end

    assign out_valid = valid_reg;
    assign pixel     = pixel_reg;

endmodule

[hdl/mc_deinterlace_pixel_merge.sv]
// ============================================================================
// mc_deinterlace_pixel_merge
// Rebuilds one missing-line pixel from source and compensated neighborhoods.
// ============================================================================
// One pixel transfer is taken on every clock edge where start is high; busy
// never rises. Each transfer gives exactly one pixel_out, marked by done for
// one cycle: the input register loads at the accepting edge, then the
// scoring register and then the result register, which drives done and
// pixel_out. The block has no state across pixels, so a new transfer may
// follow in every cycle. The receiver cannot stall: pixel_out is valid
// only in the cycle where done is high and must be captured then.
// When window_inside is low, pixel_out is mc_center unchanged.
// ============================================================================
module mc_deinterlace_pixel_merge (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [mcdi_pkg::SRC_W-1:0] src_above_row,
    input  logic [mcdi_pkg::SRC_W-1:0] src_below_row,
    input  logic [mcdi_pkg::MC_W-1:0]  mc_above_row,
    input  logic [mcdi_pkg::MC_W-1:0]  mc_below_row,
    input  mcdi_pkg::pix_t             mc_center,
    input  logic                       window_inside,
    output logic                       done,
    output mcdi_pkg::pix_t             pixel_out
);
    import mcdi_pkg::*;

    logic               accept;
    logic               in_valid_reg;
    logic [SRC_W-1:0]   src_above_reg;
    logic [SRC_W-1:0]   src_below_reg;
    logic [MC_W-1:0]    mc_above_reg;
    logic [MC_W-1:0]    mc_below_reg;
    pix_t               center_reg;
    logic               inside_reg;
    logic               score_valid;
    cand_t              cand;

    // Pipeline never back-pressures
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_above_reg <= src_above_row;
            src_below_reg <= src_below_row;
            mc_above_reg  <= mc_above_row;
            mc_below_reg  <= mc_below_row;
            center_reg    <= mc_center;
            inside_reg    <= window_inside;
        end
    end

    // Direction scores and correction differences
    mcdi_score u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .src_above (src_above_reg),
        .src_below (src_below_reg),
        .mc_above  (mc_above_reg),
        .mc_below  (mc_below_reg),
        .center    (center_reg),
        .in_window (inside_reg),
        .out_valid (score_valid),
        .cand      (cand)
    );

    // Direction pick, merge and clamp
    mcdi_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (score_valid),
        .cand      (cand),
        .out_valid (done),
        .pixel     (pixel_out)
    );

endmodule

[tb/sv/tb_mc_deinterlace_pixel_merge.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_mc_deinterlace_pixel_merge
// Self-checking bench for the missing-line pixel merge. A queue of pixel jobs
// feeds a clocked driver with random gaps. An independent predictor computes
// each expected pixel at acceptance. A clocked monitor checks every done
// strobe against the oldest expected pixel. Directed corner cases come first,
// then structured and fully random neighborhoods.
// ============================================================================
module tb_mc_deinterlace_pixel_merge;

    import mcdi_pkg::*;

    // One pixel job with its pacing
    typedef struct {
        logic [SRC_W-1:0] src_above;
        logic [SRC_W-1:0] src_below;
        logic [MC_W-1:0]  mc_above;
        logic [MC_W-1:0]  mc_below;
        pix_t             center;
        logic             in_window;
        int               gap;      // idle cycles before this transfer
        bit               drain;    // hold until all results are back
    } pixel_job_t;

    typedef struct {
        pix_t pixel;
        int   index;
    } pixel_expect_t;

    // DUT signals, known from time zero
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [SRC_W-1:0] src_above_row = '0;
    logic [SRC_W-1:0] src_below_row = '0;
    logic [MC_W-1:0]  mc_above_row = '0;
    logic [MC_W-1:0]  mc_below_row = '0;
    pix_t             mc_center = '0;
    logic             window_inside = 1'b0;
    logic             done;
    pix_t             pixel_out;

    pixel_job_t    pending_q[$];
    pixel_expect_t pixel_expect_q[$];
    pixel_job_t    cur_job;
    int            idle_count = 0;
    int            accepted_total = 0;
    int            results_total = 0;
    int            error_count = 0;

    mc_deinterlace_pixel_merge u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .src_above_row (src_above_row),
        .src_below_row (src_below_row),
        .mc_above_row  (mc_above_row),
        .mc_below_row  (mc_below_row),
        .mc_center     (mc_center),
        .window_inside (window_inside),
        .done          (done),
        .pixel_out     (pixel_out)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int iabs(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic pix_t clamp_pix(input int v);
        if (v < 0)
            return '0;
        if (v > int'(PIX_MAX))
            return PIX_MAX;
        return pix_t'(v);
    endfunction

    // Edge cost along direction dir; arrays are indexed offset+3
    function automatic int edge_cost(input int up [7], input int dn [7], input int dir);
        int k;
        int acc;
        acc = 0;
        for (k = -1; k <= 1; k++)
            acc += iabs(up[k + dir + 3] - dn[k - dir + 3]);
        return acc;
    endfunction

    function automatic pix_t predict_merge(input pixel_job_t job);
        int up [7];
        int dn [7];
        int mc_up [5];
        int mc_dn [5];
        int k;
        int side;
        int best;
        int cost;
        int d_up;
        int d_dn;
        int sum;
        int spread;
        int res;
        if (!job.in_window)
            return job.center;
        for (k = 0; k < 7; k++)
        begin
            up[k] = int'(job.src_above[8*k +: 8]);
            dn[k] = int'(job.src_below[8*k +: 8]);
        end
        for (k = 0; k < 5; k++)
        begin
            mc_up[k] = int'(job.mc_above[8*k +: 8]);
            mc_dn[k] = int'(job.mc_below[8*k +: 8]);
        end

        // vertical start, must be beaten by more than one
        d_up = mc_up[2] - up[3];
        d_dn = mc_dn[2] - dn[3];
        best = edge_cost(up, dn, 0) - 1;

        // left side first, then right; outer step only after inner wins
        for (side = -1; side <= 1; side += 2)
        begin
            cost = edge_cost(up, dn, side);
            if (cost < best)
            begin
                best = cost;
                d_up = mc_up[side + 2] - up[side + 3];
                d_dn = mc_dn[2 - side] - dn[3 - side];
                cost = edge_cost(up, dn, 2 * side);
                if (cost < best)
                begin
                    best = cost;
                    d_up = mc_up[2 * side + 2] - up[2 * side + 3];
                    d_dn = mc_dn[2 - 2 * side] - dn[3 - 2 * side];
                end
            end
        end

        // magnitude-weighted merge, truncating division
        sum = d_up + d_dn;
        spread = iabs(iabs(d_up) - iabs(d_dn));
        if (sum > 0)
            res = int'(job.center) - (sum - spread / 2) / 2;
        else
            res = int'(job.center) - (sum + spread / 2) / 2;
        return clamp_pix(res);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [SRC_W-1:0] rand_src();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[SRC_W-1:0];
    endfunction

    function automatic logic [MC_W-1:0] rand_mc();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[MC_W-1:0];
    endfunction

    // Source row as a linear ramp, optionally shifted and jittered
    function automatic logic [SRC_W-1:0] ramp_row(input int base, input int step,
                                                  input int shift, input int noise);
        logic [SRC_W-1:0] row;
        int k;
        int v;
        for (k = 0; k < 7; k++)
        begin
            v = base + step * (k - 3 + shift);
            if (noise > 0)
                v += int'($urandom_range(0, 2 * noise)) - noise;
            row[8*k +: 8] = clamp_pix(v);
        end
        return row;
    endfunction

    // Compensated row close to the matching source taps
    function automatic logic [MC_W-1:0] mc_from_src(input logic [SRC_W-1:0] src,
                                                    input int amt);
        logic [MC_W-1:0] row;
        int k;
        int v;
        for (k = 0; k < 5; k++)
        begin
            v = int'(src[8*(k+1) +: 8]) + int'($urandom_range(0, 2 * amt)) - amt;
            row[8*k +: 8] = clamp_pix(v);
        end
        return row;
    endfunction

    task automatic add_job(input logic [SRC_W-1:0] sa, input logic [SRC_W-1:0] sb,
                           input logic [MC_W-1:0] ma, input logic [MC_W-1:0] mb,
                           input pix_t ctr, input logic ins, input int gap,
                           input bit drain);
        pixel_job_t job;
        job.src_above = sa;
        job.src_below = sb;
        job.mc_above  = ma;
        job.mc_below  = mb;
        job.center    = ctr;
        job.in_window = ins;
        job.gap       = gap;
        job.drain     = drain;
        pending_q.push_back(job);
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: one transfer per accepted start
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            idle_count <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                pixel_expect_q.push_back('{pixel: predict_merge(cur_job),
                                           index: accepted_total});
                accepted_total <= accepted_total + 1;
            end
            // hold the current transfer while the block is busy
            if (!(start && busy))
            begin
                if (pending_q.size() == 0)
                    start <= 1'b0;
                else if (idle_count < pending_q[0].gap)
                begin
                    idle_count <= idle_count + 1;
                    start      <= 1'b0;
                end
                else if (pending_q[0].drain &&
                         accepted_total + ((start && !busy) ? 1 : 0) != results_total)
                    start <= 1'b0;
                else
                begin
                    cur_job        = pending_q.pop_front();
                    src_above_row <= cur_job.src_above;
                    src_below_row <= cur_job.src_below;
                    mc_above_row  <= cur_job.mc_above;
                    mc_below_row  <= cur_job.mc_below;
                    mc_center     <= cur_job.center;
                    window_inside <= cur_job.in_window;
                    start         <= 1'b1;
                    idle_count    <= 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each strobed pixel with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pixel_expect_t exp_pix;
        if (rst_n && done)
        begin
            results_total <= results_total + 1;
            if (pixel_expect_q.size() == 0)
            begin
                $display("%0t: unexpected pixel_out %0d, expected none", $time, pixel_out);
                error_count++;
            end
            else
            begin
                exp_pix = pixel_expect_q.pop_front();
                if (pixel_out !== exp_pix.pixel)
                begin
                    $display("%0t: pixel_out mismatch on transfer %0d: expected %0d, got %0d",
                             $time, exp_pix.index, exp_pix.pixel, pixel_out);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        #2000000;
        $display("mc_deinterlace_pixel_merge regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Reset, stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        logic [SRC_W-1:0] sa;
        logic [SRC_W-1:0] sb;
        logic [MC_W-1:0]  ma;
        logic [MC_W-1:0]  mb;
        int               i;
        int               kind;
        int               gap;
        bit               burst;

        // directed: flat, all-zero and all-one neighborhoods
        add_job('0, '0, '0, '0, 8'd0, 1'b1, 0, 1'b0);
        add_job('1, '1, '1, '1, 8'd255, 1'b1, 0, 1'b0);
        // window outside the image passes the center through
        add_job(rand_src(), rand_src(), rand_mc(), rand_mc(), 8'd0, 1'b0, 1, 1'b0);
        add_job('1, '1, '1, '1, 8'd255, 1'b0, 0, 1'b0);
        add_job(rand_src(), rand_src(), rand_mc(), rand_mc(), 8'd137, 1'b0, 3, 1'b0);
        // clamp at zero and at full scale
        add_job('0, '0, '1, '1, 8'd0, 1'b1, 2, 1'b0);
        add_job('1, '1, '0, '0, 8'd255, 1'b1, 0, 1'b0);
        // diagonal edges that select each direction, outer steps included
        sa = ramp_row(128, 16, 0, 0);
        add_job(sa, ramp_row(128, 16, -2, 0), mc_from_src(sa, 12),
                mc_from_src(ramp_row(128, 16, -2, 0), 12), 8'd120, 1'b1, 0, 1'b0);
        add_job(sa, ramp_row(128, 16, -4, 0), mc_from_src(sa, 12),
                mc_from_src(ramp_row(128, 16, -4, 0), 12), 8'd60, 1'b1, 4, 1'b0);
        add_job(sa, ramp_row(128, 16, 2, 0), mc_from_src(sa, 12),
                mc_from_src(ramp_row(128, 16, 2, 0), 12), 8'd200, 1'b1, 0, 1'b0);
        add_job(sa, ramp_row(128, 16, 4, 0), mc_from_src(sa, 12),
                mc_from_src(ramp_row(128, 16, 4, 0), 12), 8'd10, 1'b1, 11, 1'b0);
        // flat source, zero vertical cost: sum positive, negative and zero
        sa = {7{8'd100}};
        ma = {5{8'd100}};
        mb = {5{8'd100}};
        ma[8*2 +: 8] = 8'd107;
        mb[8*2 +: 8] = 8'd98;
        add_job(sa, sa, ma, mb, 8'd100, 1'b1, 0, 1'b0);
        ma[8*2 +: 8] = 8'd93;
        mb[8*2 +: 8] = 8'd102;
        add_job(sa, sa, ma, mb, 8'd100, 1'b1, 0, 1'b0);
        ma[8*2 +: 8] = 8'd105;
        mb[8*2 +: 8] = 8'd95;
        add_job(sa, sa, ma, mb, 8'd100, 1'b1, 5, 1'b1);
        // diagonal cost equal to vertical cost minus one: no direction wins
        sb = {7{8'd100}};
        sb[8*2 +: 8] = 8'd101;
        sb[8*3 +: 8] = 8'd101;
        sb[8*4 +: 8] = 8'd101;
        add_job(sa, sb, rand_mc(), rand_mc(), 8'd77, 1'b1, 0, 1'b0);

        // random part, paced in chunks of bursts or random gaps
        burst = 1'b0;
        for (i = 0; i < 400; i++)
        begin
            if (i % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap  = burst ? 0 : int'($urandom_range(0, 11));
            kind = int'($urandom_range(0, 9));
            if (kind == 0)
                add_job(rand_src(), rand_src(), rand_mc(), rand_mc(),
                        pix_t'($urandom()), 1'b0, gap, i == 200);
            else if (kind <= 3)
                add_job(rand_src(), rand_src(), rand_mc(), rand_mc(),
                        pix_t'($urandom()), 1'b1, gap, i == 200);
            else
            begin
                // edge-like neighborhood with small compensation error
                sa = ramp_row(int'($urandom_range(40, 215)), int'($urandom_range(0, 60)) - 30,
                              0, int'($urandom_range(0, 4)));
                sb = ramp_row(int'(sa[8*3 +: 8]), int'($urandom_range(0, 60)) - 30,
                              int'($urandom_range(0, 10)) - 5, int'($urandom_range(0, 4)));
                add_job(sa, sb, mc_from_src(sa, int'($urandom_range(0, 40))),
                        mc_from_src(sb, int'($urandom_range(0, 40))),
                        pix_t'($urandom()), 1'b1, gap, i == 200);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every transfer and every result
        while (pending_q.size() != 0 || start || accepted_total != results_total)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (pixel_expect_q.size() != 0)
        begin
            $display("%0t: %0d expected pixel(s) never arrived, oldest expected %0d",
                     $time, pixel_expect_q.size(), pixel_expect_q[0].pixel);
            error_count++;
        end

        if (error_count == 0)
            $display("mc_deinterlace_pixel_merge regression: pass");
        else
            $display("mc_deinterlace_pixel_merge regression: fail");
        $finish;
    end

endmodule
